// ===== rtl/art_pkg.sv =====
// ============================================================================
// art_pkg - shared types and constants for the address region table
// Transaction structs, operation and status codes, default sizes.
// ============================================================================
package art_pkg;

    localparam int ART_MAX_REGIONS  = 16;
    localparam int ART_ADDRESS_BITS = 32;
    localparam int ART_QUEUE_DEPTH  = 2;

    localparam logic [1:0] OP_LOOKUP = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_GAP    = 2'd2;
    localparam logic [1:0] OP_CLEAR  = 2'd3;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_NOTFOUND = 3'd1;
    localparam logic [2:0] ST_OVERLAP  = 3'd2;
    localparam logic [2:0] ST_FULL     = 3'd3;
    localparam logic [2:0] ST_OVERFLOW = 3'd4;

    typedef struct packed {
        logic [1:0]  operation;
        logic [31:0] address;
        logic [31:0] region_base;
        logic [31:0] region_size;
        logic [31:0] min_length;
        logic        search_high_first;
        logic        must_contain;
    } art_req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [3:0]  hit_index;
        logic [31:0] out_base;
        logic [31:0] out_length;
        logic [4:0]  region_count;
    } art_rsp_t;

endpackage

// ===== rtl/art_front.sv =====
// ============================================================================
// art_front - request intake and classification
// Masks the request to the address width, flags window/region end overflow,
// precomputes the window end and hands the decoded command to a small queue.
// ============================================================================
module art_front
    import art_pkg::*;
#(
    parameter int ADDRESS_BITS = ART_ADDRESS_BITS,
    parameter int QDEPTH       = ART_QUEUE_DEPTH
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    output logic     full,
    input  art_req_t req,
    output logic     cmd_valid,
    input  logic     cmd_take,
    output logic [1:0]              cmd_op,
    output logic [ADDRESS_BITS-1:0] cmd_addr,
    output logic [ADDRESS_BITS-1:0] cmd_lo,
    output logic [ADDRESS_BITS-1:0] cmd_size,
    output logic [ADDRESS_BITS-1:0] cmd_hi,
    output logic [ADDRESS_BITS-1:0] cmd_minlen,
    output logic                    cmd_high,
    output logic                    cmd_contain,
    output logic                    cmd_ovf
);
    localparam int AW  = ADDRESS_BITS;
    localparam int PW  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int EW  = 5 * AW + 5;

    logic [EW-1:0] q_reg [QDEPTH];
    logic [PW-1:0] wp_reg, rp_reg;
    logic [PW:0]   cnt_reg;
    logic [AW-1:0] a, b, s, m;
    logic [AW:0]   sum;
    logic [EW-1:0] ent, head;
    logic          do_push, do_pop;

    // mask inputs to the address width
    always_comb
    begin
        a   = AW'({32'd0, req.address});
        b   = AW'({32'd0, req.region_base});
        s   = AW'({32'd0, req.region_size});
        m   = AW'({32'd0, req.min_length});
        sum = {1'b0, b} + {1'b0, s};
        ent = {req.operation, a, b, s, sum[AW-1:0], m,
               req.search_high_first, req.must_contain, sum[AW]};
    end

    assign full    = (cnt_reg == (PW+1)'(QDEPTH));
    assign do_push = push && !full;
    assign do_pop  = cmd_valid && cmd_take;
    assign cmd_valid = (cnt_reg != '0);
    assign head    = q_reg[rp_reg];
    assign {cmd_op, cmd_addr, cmd_lo, cmd_size, cmd_hi, cmd_minlen,
            cmd_high, cmd_contain, cmd_ovf} = head;

    // command queue storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_reg[wp_reg] <= ent;
        end
    end

    // queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wp_reg <= (wp_reg == PW'(QDEPTH-1)) ? '0 : wp_reg + 1'b1;
            end
            if (do_pop)
            begin
                rp_reg <= (rp_reg == PW'(QDEPTH-1)) ? '0 : rp_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + (PW+1)'(do_push) - (PW+1)'(do_pop);
        end
    end
endmodule

// ===== rtl/art_back.sv =====
// ============================================================================
// art_back - table store and command sequencer
// Walks the sorted table one entry at a time for lookup, insert placement and
// gap search, shifts entries up one per cycle on insert, and holds the result
// in an output register.
// ============================================================================
module art_back
    import art_pkg::*;
#(
    parameter int MAX_REGIONS  = ART_MAX_REGIONS,
    parameter int ADDRESS_BITS = ART_ADDRESS_BITS
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic cmd_valid,
    output logic cmd_take,
    input  logic [1:0]              cmd_op,
    input  logic [ADDRESS_BITS-1:0] cmd_addr,
    input  logic [ADDRESS_BITS-1:0] cmd_lo,
    input  logic [ADDRESS_BITS-1:0] cmd_size,
    input  logic [ADDRESS_BITS-1:0] cmd_hi,
    input  logic [ADDRESS_BITS-1:0] cmd_minlen,
    input  logic                    cmd_high,
    input  logic                    cmd_contain,
    input  logic                    cmd_ovf,
    output logic     empty,
    input  logic     pop,
    output art_rsp_t rsp
);
    localparam int AW = ADDRESS_BITS;
    localparam int IW = $clog2(MAX_REGIONS);
    localparam int CW = IW + 1;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_READ  = 3'd1;
    localparam logic [2:0] S_EVAL  = 3'd2;
    localparam logic [2:0] S_SHIFT = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;
    localparam logic [2:0] S_LAST  = 3'd5;

    logic [AW-1:0] base_mem [MAX_REGIONS];
    logic [AW-1:0] size_mem [MAX_REGIONS];

    logic [2:0]    state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] i_reg, i_next;
    logic [AW-1:0] rb_reg, rs_reg;
    logic [AW-1:0] cur_reg, cur_next;   // lo (ascending) or hi (descending)
    logic [1:0]    op_reg;
    logic [AW-1:0] addr_reg, lob_reg, hib_reg, min_reg, nb_reg, ns_reg;
    logic          high_reg, contain_reg;
    logic          out_v_reg;
    art_rsp_t      out_reg, out_next;
    logic          finish;
    logic [CW-1:0] rd_idx;
    logic          wr_en;
    logic [IW-1:0] wr_idx;
    logic [AW-1:0] wr_b, wr_s;

    logic [AW-1:0] rend;
    logic [AW-1:0] gb, ge, glen;
    logic          gok;

    assign empty    = !out_v_reg;
    assign rsp      = out_reg;
    assign cmd_take = (state_reg == S_IDLE) && cmd_valid && !out_v_reg;
    assign rend     = rb_reg + rs_reg;

    // candidate gap [gb, ge) from the current walk position
    always_comb
    begin
        gb = lob_reg;
        ge = hib_reg;
        if (state_reg == S_LAST)
        begin
            if (!high_reg)
            begin
                gb = (cur_reg > lob_reg) ? cur_reg : lob_reg;
            end
            else
            begin
                ge = (cur_reg < hib_reg) ? cur_reg : hib_reg;
            end
        end
        else if (!high_reg)
        begin
            gb = (cur_reg > lob_reg) ? cur_reg : lob_reg;
            ge = (rb_reg < hib_reg) ? rb_reg : hib_reg;
        end
        else
        begin
            gb = (rend > lob_reg) ? rend : lob_reg;
            ge = (cur_reg < hib_reg) ? cur_reg : hib_reg;
        end
        glen = ge - gb;
        gok  = (glen >= min_reg) &&
               (!contain_reg || ((gb <= addr_reg) && ((addr_reg - gb) < glen)));
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        i_next     = i_reg;
        cur_next   = cur_reg;
        out_next   = out_reg;
        finish     = 1'b0;
        rd_idx     = i_reg;
        wr_en      = 1'b0;
        wr_idx     = i_reg[IW-1:0];
        wr_b       = nb_reg;
        wr_s       = ns_reg;
        case (state_reg)
            S_IDLE:
            begin
                out_next = '0;
                out_next.status = ST_NOTFOUND;
                if (cmd_take)
                begin
                    state_next = S_READ;
                    i_next     = (cmd_op == OP_GAP && cmd_high) ? count_reg - 1'b1 : '0;
                    cur_next   = (cmd_high) ? cmd_hi : cmd_lo;
                    case (cmd_op)
                        OP_CLEAR:
                        begin
                            count_next      = '0;
                            out_next.status = ST_OK;
                            finish          = 1'b1;
                        end
                        OP_INSERT, OP_GAP:
                        begin
                            if (cmd_ovf)
                            begin
                                out_next.status = ST_OVERFLOW;
                                finish          = 1'b1;
                            end
                            else if (cmd_op == OP_GAP && count_reg == '0)
                            begin
                                if (cmd_size >= cmd_minlen)
                                begin
                                    out_next.status     = ST_OK;
                                    out_next.out_base   = 32'(cmd_lo);
                                    out_next.out_length = 32'(cmd_size);
                                end
                                finish = 1'b1;
                            end
                            else if (count_reg == '0)
                            begin
                                state_next = S_DONE;
                            end
                        end
                        default:
                        begin
                            if (count_reg == '0)
                            begin
                                finish = 1'b1;
                            end
                        end
                    endcase
                    if (finish)
                    begin
                        state_next = S_IDLE;
                    end
                    rd_idx = (cmd_op == OP_GAP && cmd_high) ? count_reg - 1'b1 : '0;
                end
            end
            S_READ:
            begin
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                case (op_reg)
                    OP_LOOKUP:
                    begin
                        if (rb_reg <= addr_reg && (addr_reg - rb_reg) < rs_reg)
                        begin
                            out_next.status       = ST_OK;
                            out_next.hit_index    = 4'(i_reg);
                            out_next.out_base     = 32'(rb_reg);
                            out_next.out_length   = 32'(rs_reg);
                            finish = 1'b1;
                        end
                        else if (i_reg + 1'b1 == count_reg)
                        begin
                            finish = 1'b1;
                        end
                    end
                    OP_INSERT:
                    begin
                        if (nb_reg < rb_reg)
                        begin
                            if (nb_reg + ns_reg > rb_reg)
                            begin
                                out_next.status = ST_OVERLAP;
                                finish = 1'b1;
                            end
                            else
                            begin
                                state_next = S_DONE;
                            end
                        end
                        else if (nb_reg < rend)
                        begin
                            out_next.status = ST_OVERLAP;
                            finish = 1'b1;
                        end
                        else if (i_reg + 1'b1 == count_reg)
                        begin
                            i_next     = i_reg + 1'b1;
                            state_next = S_DONE;
                        end
                    end
                    default:
                    begin
                        if (!high_reg)
                        begin
                            if (rb_reg > lob_reg && rb_reg > cur_reg && gok)
                            begin
                                out_next.status     = ST_OK;
                                out_next.out_base   = 32'(gb);
                                out_next.out_length = 32'(glen);
                                finish = 1'b1;
                            end
                            else
                            begin
                                cur_next = rend;
                                if (rend >= hib_reg)
                                begin
                                    finish = 1'b1;
                                end
                                else if (i_reg + 1'b1 == count_reg)
                                begin
                                    state_next = S_LAST;
                                end
                            end
                        end
                        else
                        begin
                            if (rend < hib_reg && cur_reg > rend && gok)
                            begin
                                out_next.status     = ST_OK;
                                out_next.out_base   = 32'(gb);
                                out_next.out_length = 32'(glen);
                                finish = 1'b1;
                            end
                            else
                            begin
                                cur_next = rb_reg;
                                if (rb_reg <= lob_reg)
                                begin
                                    finish = 1'b1;
                                end
                                else if (i_reg == '0)
                                begin
                                    state_next = S_LAST;
                                end
                            end
                        end
                    end
                endcase
                if (finish)
                begin
                    state_next = S_IDLE;
                end
                else if (state_next == S_EVAL)
                begin
                    state_next = S_READ;
                    i_next     = (op_reg == OP_GAP && high_reg) ? i_reg - 1'b1 : i_reg + 1'b1;
                    rd_idx     = i_next;
                end
            end
            S_LAST:
            begin
                if (gok)
                begin
                    out_next.status     = ST_OK;
                    out_next.out_base   = 32'(gb);
                    out_next.out_length = 32'(glen);
                end
                finish     = 1'b1;
                state_next = S_IDLE;
            end
            S_DONE:
            begin
                // insert position found in i_reg
                if (count_reg == CW'(MAX_REGIONS))
                begin
                    out_next.status = ST_FULL;
                    finish     = 1'b1;
                    state_next = S_IDLE;
                end
                else if (count_reg == i_reg)
                begin
                    // append: nothing to move
                    state_next = S_SHIFT;
                    cur_next   = AW'(i_reg);
                end
                else
                begin
                    state_next = S_SHIFT;
                    i_next     = count_reg;
                    rd_idx     = count_reg - 1'b1;
                    cur_next   = AW'(i_reg);
                end
            end
            S_SHIFT:
            begin
                // move entries up one per cycle, then place the new region
                if (i_reg == cur_reg[CW-1:0])
                begin
                    wr_en  = 1'b1;
                    wr_idx = i_reg[IW-1:0];
                    wr_b   = nb_reg;
                    wr_s   = ns_reg;
                    out_next.status     = ST_OK;
                    out_next.hit_index  = 4'(i_reg);
                    out_next.out_base   = 32'(nb_reg);
                    out_next.out_length = 32'(ns_reg);
                    count_next = count_reg + 1'b1;
                    finish     = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    wr_en  = 1'b1;
                    wr_idx = i_reg[IW-1:0];
                    wr_b   = rb_reg;
                    wr_s   = rs_reg;
                    i_next = i_reg - 1'b1;
                    rd_idx = i_reg - 2'd2;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        out_next.region_count = 5'(count_next);
    end

    // table memory: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            base_mem[wr_idx] <= wr_b;
            size_mem[wr_idx] <= wr_s;
        end
        rb_reg <= base_mem[rd_idx[IW-1:0]];
        rs_reg <= size_mem[rd_idx[IW-1:0]];
    end

    // command capture; the result register starts from not-found on take
    always_ff @(posedge clk)
    begin
        if (cmd_take)
        begin
            op_reg      <= cmd_op;
            addr_reg    <= cmd_addr;
            lob_reg     <= cmd_lo;
            hib_reg     <= cmd_hi;
            min_reg     <= cmd_minlen;
            high_reg    <= cmd_high;
            contain_reg <= cmd_contain;
            nb_reg      <= cmd_lo;
            ns_reg      <= cmd_size;
        end
        cur_reg <= cur_next;
        if (finish || cmd_take)
        begin
            out_reg <= out_next;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            i_reg     <= '0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            i_reg     <= i_next;
            if (finish)
            begin
                out_v_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_v_reg <= 1'b0;
            end
        end
    end
endmodule

// ===== rtl/address_region_table_core.sv =====
// ============================================================================
// address_region_table_core - sorted address region table with gap search
// Front end decodes and queues requests; back end owns the table and runs
// lookup, ordered insert, windowed gap search and clear.
// ============================================================================
//  channel   | handshake          | payload
//  request   | push / full        | req (art_req_t)
//  response  | empty / pop        | rsp (art_rsp_t)
//
//  Clear and early rejects finish in the take cycle; lookup and gap search
//  visit each entry as a registered read, then a compare, gap search adding
//  a final step for the gap past the last region visited. Insert walks to its
//  slot the same way, checks capacity, moves one entry per cycle, then places.
//  Reset empties the table; contents are not cleared. A held response stalls
//  the back end, the two-entry front queue keeps accepting meanwhile.
module address_region_table_core
    import art_pkg::*;
#(
    parameter int MAX_REGIONS  = ART_MAX_REGIONS,
    parameter int ADDRESS_BITS = ART_ADDRESS_BITS
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    output logic     full,
    input  art_req_t req,
    output logic     empty,
    input  logic     pop,
    output art_rsp_t rsp
);
    localparam int AW = ADDRESS_BITS;

    logic          cmd_valid, cmd_take, cmd_high, cmd_contain, cmd_ovf;
    logic [1:0]    cmd_op;
    logic [AW-1:0] cmd_addr, cmd_lo, cmd_size, cmd_hi, cmd_minlen;

    art_front #(.ADDRESS_BITS(ADDRESS_BITS)) u_front (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .req(req),
        .cmd_valid(cmd_valid), .cmd_take(cmd_take), .cmd_op(cmd_op),
        .cmd_addr(cmd_addr), .cmd_lo(cmd_lo), .cmd_size(cmd_size),
        .cmd_hi(cmd_hi), .cmd_minlen(cmd_minlen), .cmd_high(cmd_high),
        .cmd_contain(cmd_contain), .cmd_ovf(cmd_ovf)
    );

    art_back #(.MAX_REGIONS(MAX_REGIONS), .ADDRESS_BITS(ADDRESS_BITS)) u_back (
        .clk(clk), .rst_n(rst_n), .cmd_valid(cmd_valid), .cmd_take(cmd_take),
        .cmd_op(cmd_op), .cmd_addr(cmd_addr), .cmd_lo(cmd_lo),
        .cmd_size(cmd_size), .cmd_hi(cmd_hi), .cmd_minlen(cmd_minlen),
        .cmd_high(cmd_high), .cmd_contain(cmd_contain), .cmd_ovf(cmd_ovf),
        .empty(empty), .pop(pop), .rsp(rsp)
    );

`ifndef SYNTHESIS
    // region count never exceeds capacity
    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> rsp.region_count <= 5'(MAX_REGIONS))
        else $error("region count above capacity");
    // failed results carry zero payload
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && rsp.status != ST_OK) |-> (rsp.out_base == '0 && rsp.hit_index == '0))
        else $error("failure with payload");
    // a waiting response holds until popped
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(rsp)))
        else $error("response changed while waiting");
`endif
endmodule
